// ===== hw/rtl/cms_pkg.sv =====
// Package for the CoAP message serializer: opcodes, header constants,
// the per-item burst record and the option nibble helper. No dependencies.
`default_nettype none

package cms_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_OPTION  = 2'd1,
    OP_DATA    = 2'd2,
    OP_PAYLOAD = 2'd3
  } opcode_t;

  localparam logic [7:0]  HDR_FIRST     = 8'h40;  // version 1, CON, no token
  localparam logic [7:0]  HDR_CODE_POST = 8'h02;
  localparam logic [7:0]  PAYLOAD_MARK  = 8'hFF;
  localparam logic [15:0] EXT1_BASE     = 16'd13;
  localparam logic [15:0] EXT2_BASE     = 16'd269;
  localparam logic [3:0]  NIB_EXT1      = 4'd13;
  localparam logic [3:0]  NIB_EXT2      = 4'd14;
  localparam logic [15:0] CAPACITY_RST  = 16'd512;
  localparam int          MAX_RESULTS   = 5;

  // One accepted item, worked out: the results it causes and the new state.
  typedef struct packed {
    logic                        emit;      // item causes at least one result
    logic                        fail;      // single no-space status result
    logic [2:0]                  cnt;       // results, 1..5
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [15:0]                 base_len;  // message length before first byte
    logic [15:0]                 next_len;
    logic [15:0]                 next_opt;
  } plan_t;

  function automatic logic [3:0] nibble_of(input logic [15:0] v);
    logic [3:0] n;
    if (v < EXT1_BASE) begin
      n = v[3:0];
    end else if (v < EXT2_BASE) begin
      n = NIB_EXT1;
    end else begin
      n = NIB_EXT2;
    end
    return n;
  endfunction

  // Number of extended bytes for a delta or length value.
  function automatic logic [1:0] ext_count(input logic [15:0] v);
    logic [1:0] c;
    if (v < EXT1_BASE) begin
      c = 2'd0;
    end else if (v < EXT2_BASE) begin
      c = 2'd1;
    end else begin
      c = 2'd2;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cms_encoder.sv =====
// Item encoder: turns one input word plus the running message state into
// the list of bytes to send, the space check and the next state. Uses cms_pkg.
`default_nettype none

module cms_encoder
  import cms_pkg::*;
(
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] msg_id,
  input  wire logic [15:0] opt_num,
  input  wire logic [15:0] item_length,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] capacity,
  input  wire logic [15:0] message_length,
  input  wire logic [15:0] last_option,
  output plan_t            plan
);

  logic [15:0] delta;
  logic [1:0]  dn;
  logic [1:0]  ln;
  logic [15:0] d_ext;
  logic [15:0] l_ext;
  logic [17:0] need_total;
  logic [2:0]  opt_cnt;
  logic [MAX_RESULTS-1:0][7:0] opt_bytes;

  assign delta = opt_num - last_option;
  assign dn    = ext_count(delta);
  assign ln    = ext_count(item_length);
  assign d_ext = (dn == 2'd2) ? (delta - EXT2_BASE) : (delta - EXT1_BASE);
  assign l_ext = (ln == 2'd2) ? (item_length - EXT2_BASE) : (item_length - EXT1_BASE);
  assign opt_cnt = 3'd1 + {1'b0, dn} + {1'b0, ln};

  // Nibble byte, then extended delta bytes, then extended length bytes.
  always_comb begin
    opt_bytes    = '0;
    opt_bytes[0] = {nibble_of(delta), nibble_of(item_length)};
    unique case (dn)
      2'd1:    opt_bytes[1] = d_ext[7:0];
      2'd2:    begin
        opt_bytes[1] = d_ext[15:8];
        opt_bytes[2] = d_ext[7:0];
      end
      default: ;
    endcase
    unique case (ln)
      2'd1:    opt_bytes[3'd1 + {1'b0, dn}] = l_ext[7:0];
      2'd2:    begin
        opt_bytes[3'd1 + {1'b0, dn}] = l_ext[15:8];
        opt_bytes[3'd2 + {1'b0, dn}] = l_ext[7:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    plan          = '0;
    plan.emit     = 1'b1;
    plan.base_len = message_length;
    plan.next_len = message_length;
    plan.next_opt = last_option;
    need_total    = {2'b0, message_length} + 18'd1;
    unique case (opcode_t'(opcode))
      OP_BEGIN: begin
        plan.base_len = '0;
        plan.next_opt = '0;
        plan.fail     = (capacity < 16'd4);
        plan.cnt      = 3'd4;
        plan.bytes[0] = HDR_FIRST;
        plan.bytes[1] = HDR_CODE_POST;
        plan.bytes[2] = msg_id[15:8];
        plan.bytes[3] = msg_id[7:0];
        plan.next_len = plan.fail ? 16'd0 : 16'd4;
      end
      OP_OPTION: begin
        need_total    = {2'b0, message_length} + {15'b0, opt_cnt} + {2'b0, item_length};
        plan.fail     = (need_total > {2'b0, capacity});
        plan.cnt      = opt_cnt;
        plan.bytes    = opt_bytes;
        if (!plan.fail) begin
          plan.next_len = message_length + {13'b0, opt_cnt};
          plan.next_opt = opt_num;
        end
      end
      OP_DATA: begin
        plan.fail     = (need_total > {2'b0, capacity});
        plan.cnt      = 3'd1;
        plan.bytes[0] = data_byte;
        if (!plan.fail) plan.next_len = message_length + 16'd1;
      end
      OP_PAYLOAD: begin
        need_total    = {2'b0, message_length} + 18'd1 + {2'b0, item_length};
        plan.emit     = (item_length != 16'd0);
        plan.fail     = (need_total > {2'b0, capacity});
        plan.cnt      = 3'd1;
        plan.bytes[0] = PAYLOAD_MARK;
        if (!plan.fail && plan.emit) plan.next_len = message_length + 16'd1;
      end
      default: ;
    endcase
    if (plan.fail) plan.cnt = 3'd1;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/coap_message_serializer_core.sv =====
// Top level of the CoAP message serializer: APB capacity register, message
// state, burst register and output sequencing. Uses cms_pkg and cms_encoder.
//
// Each accepted word is encoded in the cycle it is taken and loaded into a
// burst register that doubles as the output register; the burst then leaves
// one result per cycle while out_ready is high. A data byte or payload
// marker is one result, an option header 1 to 5 results (nibble byte plus
// extended bytes), a begin 4, a no-space status one, and an empty payload
// start none. The next word is taken in the same cycle as the last result
// of a burst, so byte streams run at one word per cycle while out_ready
// stays high. The capacity register sits at byte address 0, resets to 512.
`default_nettype none

module coap_message_serializer_core
  import cms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] msg_id,
  input  wire logic [15:0] opt_num,
  input  wire logic [15:0] item_length,
  input  wire logic [7:0]  data_byte,
  // output channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_byte,
  output      logic        byte_valid,
  output      logic        last,
  output      logic        status,
  output      logic [15:0] msg_length
);

  logic [15:0] capacity;
  logic [15:0] message_length;
  logic [15:0] last_option;
  logic        busy;
  logic [2:0]  idx;
  plan_t       burst;
  plan_t       plan;
  logic        in_fire;
  logic        out_fire;
  logic        cfg_write;

  // Register index is the word address; only index 0 exists.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {16'b0, capacity} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_write && paddr[2] == 1'b0) begin
      capacity <= pwdata[15:0];
    end
  end

  cms_encoder u_encoder (
    .opcode         (opcode),
    .msg_id         (msg_id),
    .opt_num        (opt_num),
    .item_length    (item_length),
    .data_byte      (data_byte),
    .capacity       (capacity),
    .message_length (message_length),
    .last_option    (last_option),
    .plan           (plan)
  );

  assign out_valid = busy;
  assign last      = (idx == burst.cnt - 3'd1);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = !busy || (out_ready && last);
  assign in_fire   = in_valid && in_ready;

  assign status     = burst.fail;
  assign byte_valid = !burst.fail;
  assign out_byte   = burst.fail ? 8'h00 : burst.bytes[idx];
  assign msg_length = burst.fail ? burst.base_len
                                 : burst.base_len + {13'b0, idx} + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= '0;
      last_option    <= '0;
    end else if (in_fire) begin
      message_length <= plan.next_len;
      last_option    <= plan.next_opt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_fire) begin
      busy <= plan.emit;
      idx  <= '0;
    end else if (out_fire) begin
      // advance through the burst, drop busy after its last word
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Burst payload: loaded on accept, held until the burst drains.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      burst <= plan;
    end
  end

endmodule

`default_nettype wire
